[rtl/core/mf3_pkg.sv]
`default_nettype none
package mf3_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 512;
    localparam int unsigned MAX_HEIGHT_DEF = 512;
    localparam int unsigned PIXEL_BITS_DEF = 8;

    // window taps and their arrangement
    localparam int unsigned WIN_TAPS = 9;
    localparam int unsigned WIN_SIDE = 3;

    // configuration register file
    localparam int unsigned CFG_W     = 10;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_RESET = 512;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // per-pixel status that travels with the pixel through the line store stage
    typedef struct packed {
        logic emit;
        logic last;
    } t_pix_tag;

endpackage
`default_nettype wire

[rtl/core/median_filter_3x3_core.sv]
`default_nettype none
// 3x3 median filter on a raster-order grey pixel stream. Frame width and height are set
// through the configuration port (index 0 width, index 1 height; zero acts as one, values
// above the maximum are clamped) and may be written whenever no pixel is in flight; a
// write in mid-frame keeps the raster position. One pixel is taken every clock unless the
// output stalls; each result passes through the line store, window and sorting registers.
// The rate is held by the single line store RAM, which is read once and written
// once per pixel, with bypass when consecutive pixels hit the same entry, and by a
// three-stage sorting network. Pixels in the first two rows and columns of a frame give
// no result; o_frame_last marks the final median of a frame. Frames smaller than 3x3
// give no result at all. The line store needs no clearing after reset.
module median_filter_3x3_core #(
    parameter int unsigned MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_pixel_valid,
    output logic                               o_pixel_ready,
    input  wire logic [PIXEL_BITS-1:0]         i_pixel,
    output logic                               o_median_valid,
    input  wire logic                          i_median_ready,
    output logic [PIXEL_BITS-1:0]              o_median_value,
    output logic                               o_frame_last
);

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned EWW = (CW + 1 > mf3_pkg::CFG_W) ? CW + 1 : mf3_pkg::CFG_W;
    localparam int unsigned EWH = (RW + 1 > mf3_pkg::CFG_W) ? RW + 1 : mf3_pkg::CFG_W;
    localparam int unsigned RST_W_I = (mf3_pkg::CFG_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                       : mf3_pkg::CFG_RESET;
    localparam int unsigned RST_H_I = (mf3_pkg::CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                        : mf3_pkg::CFG_RESET;
    localparam logic [CW:0] RST_W = (CW + 1)'(RST_W_I);
    localparam logic [RW:0] RST_H = (RW + 1)'(RST_H_I);
    localparam int unsigned NT = mf3_pkg::WIN_TAPS;
    localparam int unsigned NS = mf3_pkg::WIN_SIDE;

    typedef logic [NT-1:0][PIXEL_BITS-1:0] t_win;

    logic [CW:0]   r_width;
    logic [RW:0]   r_height;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [EWW-1:0] cfg_w_ext, cfg_w_clamp;
    logic [EWH-1:0] cfg_h_ext, cfg_h_clamp;

    logic row_end, frame_end, accept;
    mf3_pkg::t_pix_tag tag;

    logic                  lb_valid;
    logic [PIXEL_BITS-1:0] lb_row_b, lb_row_a, lb_pixel;
    mf3_pkg::t_pix_tag     lb_tag;
    logic                  lb_depart;

    t_win r_win;
    t_win n_win;
    logic r_s2_valid;
    t_win r_s2_win;
    logic r_s2_last;
    logic med_ready;
    logic en2;

    // configuration
    assign o_cfg_ready = 1'b1;
    assign cfg_w_ext   = EWW'(i_cfg_data);
    assign cfg_h_ext   = EWH'(i_cfg_data);

    always_comb begin
        if (cfg_w_ext == '0) begin
            cfg_w_clamp = EWW'(1);
        end else if (cfg_w_ext > EWW'(MAX_WIDTH)) begin
            cfg_w_clamp = EWW'(MAX_WIDTH);
        end else begin
            cfg_w_clamp = cfg_w_ext;
        end
        if (cfg_h_ext == '0) begin
            cfg_h_clamp = EWH'(1);
        end else if (cfg_h_ext > EWH'(MAX_HEIGHT)) begin
            cfg_h_clamp = EWH'(MAX_HEIGHT);
        end else begin
            cfg_h_clamp = cfg_h_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_W;
            r_height <= RST_H;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mf3_pkg::REG_FRAME_WIDTH: begin
                    r_width <= cfg_w_clamp[CW:0];
                end
                mf3_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= cfg_h_clamp[RW:0];
                end
                default: begin
                end
            endcase
        end
    end

    // raster position
    assign row_end   = ({1'b0, r_col} + (CW + 1)'(1)) >= r_width;
    assign frame_end = row_end && (({1'b0, r_row} + (RW + 1)'(1)) >= r_height);
    assign tag.emit  = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign tag.last  = frame_end;

    assign lb_depart     = lb_valid && en2;
    assign o_pixel_ready = !lb_valid || en2;
    assign accept        = i_pixel_valid && o_pixel_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    mf3_line_buf #(
        .DEPTH      (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_addr  (r_col),
        .i_pixel (i_pixel),
        .i_tag   (tag),
        .i_adv   (en2),
        .o_valid (lb_valid),
        .o_row_b (lb_row_b),
        .o_row_a (lb_row_a),
        .o_pixel (lb_pixel),
        .o_tag   (lb_tag)
    );

    // window shifts one column per pixel, newest column in the top taps
    always_comb begin
        for (int k = 0; k < NT - NS; k++) begin
            n_win[k] = r_win[k + NS];
        end
        n_win[NT-3] = lb_row_b;
        n_win[NT-2] = lb_row_a;
        n_win[NT-1] = lb_pixel;
    end

    assign en2 = !r_s2_valid || med_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            if (lb_depart) begin
                r_win <= n_win;
            end
            if (en2) begin
                r_s2_valid <= lb_valid && lb_tag.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lb_depart && lb_tag.emit) begin
            r_s2_win  <= n_win;
            r_s2_last <= lb_tag.last;
        end
    end

    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .o_ready  (med_ready),
        .i_win    (r_s2_win),
        .i_last   (r_s2_last),
        .o_valid  (o_median_valid),
        .i_ready  (i_median_ready),
        .o_median (o_median_value),
        .o_last   (o_frame_last)
    );

endmodule
`default_nettype wire

[rtl/core/mf3_line_buf.sv]
`default_nettype none
module mf3_line_buf #(
    parameter int unsigned DEPTH      = mf3_pkg::MAX_WIDTH_DEF,
    parameter int unsigned PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [$clog2(DEPTH)-1:0]      i_addr,
    input  wire logic [PIXEL_BITS-1:0]         i_pixel,
    input  wire mf3_pkg::t_pix_tag             i_tag,
    input  wire logic                          i_adv,
    output logic                               o_valid,
    output logic [PIXEL_BITS-1:0]              o_row_b,
    output logic [PIXEL_BITS-1:0]              o_row_a,
    output logic [PIXEL_BITS-1:0]              o_pixel,
    output mf3_pkg::t_pix_tag                  o_tag
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned DW = 2 * PIXEL_BITS;

    // each entry packs the two previous rows: upper half is row r-2, lower is row r-1
    logic [DW-1:0] mem [DEPTH];

    logic                  r_valid;
    logic [AW-1:0]         r_addr;
    logic [PIXEL_BITS-1:0] r_pixel;
    mf3_pkg::t_pix_tag     r_tag;
    logic [DW-1:0]         r_q;
    logic                  r_fwd;
    logic [DW-1:0]         r_fwd_data;

    logic                  depart;
    logic [DW-1:0]         entry;
    logic [DW-1:0]         wr_data;

    assign depart  = r_valid & i_adv;
    // a read issued on the edge that writes the same entry sees the new value
    assign entry   = r_fwd ? r_fwd_data : r_q;
    assign wr_data = {entry[PIXEL_BITS-1:0], r_pixel};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= mem[i_addr];
        end
        if (depart) begin
            mem[r_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_fwd   <= depart && (r_addr == i_addr);
            end else if (depart) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr     <= i_addr;
            r_pixel    <= i_pixel;
            r_tag      <= i_tag;
            r_fwd_data <= wr_data;
        end
    end

    assign o_valid = r_valid;
    assign o_row_b = entry[DW-1:PIXEL_BITS];
    assign o_row_a = entry[PIXEL_BITS-1:0];
    assign o_pixel = r_pixel;
    assign o_tag   = r_tag;

endmodule
`default_nettype wire

[rtl/core/mf3_median.sv]
`default_nettype none
module mf3_median #(
    parameter int unsigned PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_valid,
    output logic                                             o_ready,
    input  wire logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] i_win,
    input  wire logic                                        i_last,
    output logic                                             o_valid,
    input  wire logic                                        i_ready,
    output logic [PIXEL_BITS-1:0]                            o_median,
    output logic                                             o_last
);

    typedef logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] t_win;

    // compare and exchange: lower value ends up at index a
    function automatic t_win cas(input t_win w, input int unsigned a, input int unsigned b);
        t_win res;
        res = w;
        if (w[a] > w[b]) begin
            res[a] = w[b];
            res[b] = w[a];
        end
        return res;
    endfunction

    // sort each column of three
    function automatic t_win net_cols(input t_win w);
        t_win t;
        t = w;
        t = cas(t, 1, 2);
        t = cas(t, 4, 5);
        t = cas(t, 7, 8);
        t = cas(t, 0, 1);
        t = cas(t, 3, 4);
        t = cas(t, 6, 7);
        t = cas(t, 1, 2);
        t = cas(t, 4, 5);
        t = cas(t, 7, 8);
        return t;
    endfunction

    // drop the extremes across columns
    function automatic t_win net_cross(input t_win w);
        t_win t;
        t = w;
        t = cas(t, 0, 3);
        t = cas(t, 5, 8);
        t = cas(t, 4, 7);
        t = cas(t, 3, 6);
        t = cas(t, 1, 4);
        t = cas(t, 2, 5);
        return t;
    endfunction

    // settle the centre, median lands in tap 4
    function automatic t_win net_mid(input t_win w);
        t_win t;
        t = w;
        t = cas(t, 4, 7);
        t = cas(t, 2, 4);
        t = cas(t, 4, 6);
        t = cas(t, 2, 4);
        return t;
    endfunction

    logic                  r_va, r_vb, r_vo;
    t_win                  r_wa, r_wb;
    logic                  r_la, r_lb, r_lo;
    logic [PIXEL_BITS-1:0] r_med;
    t_win                  mid_w;

    logic en_o, en_b, en_a;

    assign en_o    = !r_vo || i_ready;
    assign en_b    = !r_vb || en_o;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign mid_w   = net_mid(r_wb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_o) begin
                r_vo <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_wa <= net_cols(i_win);
            r_la <= i_last;
        end
        if (en_b && r_va) begin
            r_wb <= net_cross(r_wa);
            r_lb <= r_la;
        end
        if (en_o && r_vb) begin
            r_med <= mid_w[4];
            r_lo  <= r_lb;
        end
    end

    assign o_valid  = r_vo;
    assign o_median = r_med;
    assign o_last   = r_lo;

endmodule
`default_nettype wire

[tb/sv/median_filter_3x3_core_tb.sv]
`default_nettype none
module median_filter_3x3_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mf3_pkg::*;

    localparam int unsigned MAX_W         = MAX_WIDTH_DEF;
    localparam int unsigned MAX_H         = MAX_HEIGHT_DEF;
    localparam int unsigned PIX_W         = PIXEL_BITS_DEF;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned PHASE_PIXELS  = 40;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel value;
        logic   last;
    } t_median_beat;

    class median_tracker;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_pixel           line_prev[MAX_W];
        t_pixel           line_prev2[MAX_W];
        bit [1:0]         col_fill[MAX_W];
        t_pixel           win[9];
        int unsigned      col;
        int unsigned      row;
        int unsigned      pixels_in;
        int unsigned      fails;
        t_median_beat     medians_due[$];

        function new();
            int i;
            width_reg  = CFG_W'(CFG_RESET);
            height_reg = CFG_W'(CFG_RESET);
            for (i = 0; i < MAX_W; i++) begin
                line_prev[i]  = '0;
                line_prev2[i] = '0;
                col_fill[i]   = 2'd0;
            end
            for (i = 0; i < 9; i++) begin
                win[i] = '0;
            end
            col       = 0;
            row       = 0;
            pixels_in = 0;
            fails     = 0;
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned ceiling);
            if (v == 0) begin
                return 1;
            end
            return (v > ceiling) ? ceiling : int'(v);
        endfunction

        function int unsigned frame_w();
            return clamp_dim(width_reg, MAX_W);
        endfunction

        function int unsigned frame_h();
            return clamp_dim(height_reg, MAX_H);
        endfunction

        // leading columns whose line store entry has had both rows written since reset
        function int unsigned seasoned_width();
            int unsigned n;
            n = 0;
            while (n < MAX_W && col_fill[n] == 2'd2) begin
                n++;
            end
            return n;
        endfunction

        function int unsigned pixels_to_frame_end();
            int unsigned w;
            int unsigned h;
            int unsigned rest_row;
            int unsigned rows_after;
            w = frame_w();
            h = frame_h();
            rest_row   = (col + 1 >= w) ? 1 : w - col;
            rows_after = (row + 1 >= h) ? 0 : h - row - 1;
            return rest_row + rows_after * w;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_FRAME_WIDTH: begin
                    width_reg = data;
                end
                REG_FRAME_HEIGHT: begin
                    height_reg = data;
                end
                default: begin
                end
            endcase
        endfunction

        function t_pixel window_median();
            t_pixel s[9];
            t_pixel t;
            int     i;
            int     j;
            s = win;
            for (i = 1; i < 9; i++) begin
                j = i;
                while (j > 0 && s[j] < s[j-1]) begin
                    t      = s[j];
                    s[j]   = s[j-1];
                    s[j-1] = t;
                    j--;
                end
            end
            return s[4];
        endfunction

        function void take_pixel(t_pixel p);
            int unsigned  w;
            int unsigned  h;
            int unsigned  idx;
            int unsigned  k;
            logic         row_end;
            logic         frame_end;
            t_median_beat beat;
            w = frame_w();
            h = frame_h();
            idx = (col < MAX_W) ? col : MAX_W - 1;
            row_end   = (col + 1 >= w);
            frame_end = row_end && (row + 1 >= h);
            for (k = 0; k < 6; k++) begin
                win[k] = win[k+3];
            end
            win[6] = line_prev2[idx];
            win[7] = line_prev[idx];
            win[8] = p;
            line_prev2[idx] = line_prev[idx];
            line_prev[idx]  = p;
            if (col_fill[idx] != 2'd2) begin
                col_fill[idx]++;
            end
            if (row >= 2 && col >= 2) begin
                beat.value = window_median();
                beat.last  = frame_end;
                medians_due.push_back(beat);
            end
            if (row_end) begin
                col = 0;
                row = frame_end ? 0 : row + 1;
            end else begin
                col++;
            end
            pixels_in++;
        endfunction

        function void check_median(t_pixel value, logic last);
            t_median_beat due;
            if (medians_due.size() == 0) begin
                $error("median beat with none due: median_value=%0d frame_last=%0d",
                       value, last);
                fails++;
                return;
            end
            due = medians_due.pop_front();
            if (value !== due.value) begin
                $error("median_value: expected %0d, actual %0d", due.value, value);
                fails++;
            end
            if (last !== due.last) begin
                $error("frame_last: expected %0d, actual %0d", due.last, last);
                fails++;
            end
        endfunction
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_pixel_valid  = 1'b0;
    logic                 o_pixel_ready;
    t_pixel               i_pixel        = '0;
    logic                 o_median_valid;
    logic                 i_median_ready = 1'b0;
    t_pixel               o_median_value;
    logic                 o_frame_last;

    median_tracker tracker = new();
    t_pixel        directed_px[$];
    t_pixel        pixel_base         = '0;
    int unsigned   sender_idle_pct    = 0;
    int unsigned   receiver_stall_pct = 0;
    int unsigned   quiet_cycles       = 0;

    median_filter_3x3_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .o_median_valid (o_median_valid),
        .i_median_ready (i_median_ready),
        .o_median_value (o_median_value),
        .o_frame_last   (o_frame_last)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_median_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // every accepted beat feeds the tracker; a long run without any beat ends the test
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.set_reg(i_cfg_index, i_cfg_data);
            end
            if (i_pixel_valid && o_pixel_ready) begin
                tracker.take_pixel(i_pixel);
            end
            if (o_median_valid && i_median_ready) begin
                tracker.check_median(o_median_value, o_frame_last);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_pixel_valid && o_pixel_ready) ||
                (o_median_valid && i_median_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("median_filter_3x3_core regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_pixel next_pixel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return ($urandom_range(1) != 0) ? '1 : '0;
        end
        // clustered values give plenty of ties in the window
        if (roll < 40) begin
            return pixel_base + t_pixel'($urandom_range(3));
        end
        return t_pixel'($urandom_range(255));
    endfunction

    function automatic int unsigned pick_size(int unsigned big);
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return $urandom_range(2);
        end
        if (roll == 1) begin
            return $urandom_range(big, 10);
        end
        return $urandom_range(8, 3);
    endfunction

    task automatic send_pixels(int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            @(negedge i_clk);
            if ($urandom_range(99) < sender_idle_pct) begin
                i_pixel_valid <= 1'b0;
            end else begin
                i_pixel_valid <= 1'b1;
                i_pixel <= (directed_px.size() != 0) ? directed_px.pop_front() : next_pixel();
                do @(posedge i_clk); while (!o_pixel_ready);
                sent++;
            end
        end
        @(negedge i_clk);
        i_pixel_valid <= 1'b0;
    endtask

    // only with the block idle: all medians back, then SETTLE_CYCLES of settling
    task automatic write_cfg(logic [CFG_IDX_W-1:0] index, int unsigned value);
        while (tracker.medians_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        write_cfg(REG_FRAME_WIDTH, w);
        write_cfg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic random_segment();
        int unsigned frames;
        int unsigned part;
        int unsigned wide;
        int unsigned new_w;
        pixel_base = t_pixel'($urandom_range(255));
        set_frame(pick_size(40), pick_size(12));
        frames = $urandom_range(3, 1);
        if ($urandom_range(99) < 25) begin
            part = $urandom_range(tracker.pixels_to_frame_end() - 1);
            send_pixels(part);
            // widening mid-frame only over columns already written twice
            wide = tracker.seasoned_width();
            if (wide > 48) begin
                wide = 48;
            end
            if ($urandom_range(1) == 0 || wide <= tracker.frame_w()) begin
                new_w = $urandom_range(tracker.frame_w());
            end else begin
                new_w = $urandom_range(wide, tracker.frame_w());
            end
            write_cfg(REG_FRAME_WIDTH, new_w);
            write_cfg(REG_FRAME_HEIGHT, pick_size(12));
            send_pixels(tracker.pixels_to_frame_end());
            frames--;
        end
        send_pixels(frames * tracker.pixels_to_frame_end());
    endtask

    initial begin
        int unsigned phase;
        int unsigned start;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one 3x3 frame, two 1x1 frames from zero sizes, then a height cut mid-frame
        directed_px = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h01,
                        8'h55, 8'hAA,
                        8'h7F, 8'h80, 8'hFE, 8'h01, 8'h40, 8'hBF, 8'h20, 8'hDF, 8'h10,
                        8'hEF, 8'h08, 8'hF7};
        set_frame(3, 3);
        send_pixels(9);
        set_frame(0, 0);
        send_pixels(2);
        set_frame(3, 4);
        send_pixels(9);
        write_cfg(REG_FRAME_HEIGHT, 3);
        send_pixels(tracker.pixels_to_frame_end());

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 64;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 64;
                end
                default: begin
                    sender_idle_pct    = 19;
                    receiver_stall_pct = 19;
                end
            endcase
            if (phase == 0) begin
                // widest line and tallest frame, both past the clamp
                set_frame(1023, 1);
                send_pixels(tracker.pixels_to_frame_end());
                set_frame(1, 1023);
                send_pixels(tracker.pixels_to_frame_end());
            end
            start = tracker.pixels_in;
            while (tracker.pixels_in - start < PHASE_PIXELS) begin
                random_segment();
            end
        end

        while (tracker.medians_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (tracker.fails == 0) begin
            $display("median_filter_3x3_core regression: pass");
        end else begin
            $display("median_filter_3x3_core regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
